/* sv/temp_sensor_plausibility_filter_core_macros.svh */
// Assertion helpers for the plausibility filter; they expect clk and rst_n in scope.
`ifndef TEMP_SENSOR_PLAUSIBILITY_FILTER_CORE_MACROS_SVH
`define TEMP_SENSOR_PLAUSIBILITY_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TSPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TSPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSPF_ASSERT_NOW(label, ante, cons, msg)
`define TSPF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* sv/tspf_pkg.sv */
`timescale 1ns / 1ps
package tspf_pkg;

    localparam int TEMP_W     = 12;
    localparam int RAW_W      = 16;
    localparam int CNT_W      = 4;
    localparam int TOL_W      = 11;
    localparam int SIDX_W     = 3;
    localparam int MAP_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TOLERANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PARTNER_TOLERANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_COUNT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PARTNER_MAP       = 3'd6;

    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    typedef enum logic [2:0] {
        EV_ACCEPTED         = 3'd0,
        EV_SEEDED           = 3'd1,
        EV_PARTNER_SUB      = 3'd2,
        EV_FAIL_HOLD        = 3'd3,
        EV_RANGE_HOLD       = 3'd4,
        EV_JUMP_HOLD        = 3'd5,
        EV_RECOVERED        = 3'd6,
        EV_PARTNER_DISAGREE = 3'd7
    } event_t;

    typedef struct packed {
        logic [TOL_W-1:0]  jump_limit;
        logic [TEMP_W-1:0] low_limit;
        logic [TEMP_W-1:0] high_limit;
        logic [TOL_W-1:0]  repeat_tolerance;
        logic [TOL_W-1:0]  partner_tolerance;
        logic [CNT_W-1:0]  recover_count;
        logic [MAP_W-1:0]  partner_map;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        jump_limit:        11'd160,
        low_limit:         12'hD80,   // -640
        high_limit:        12'd1360,
        repeat_tolerance:  11'd48,
        partner_tolerance: 11'd80,
        recover_count:     4'd3,
        partner_map:       24'h8474F5
    };

    typedef struct packed {
        logic [TEMP_W-1:0] last_good;
        logic [TEMP_W-1:0] rejected_value;
        logic [CNT_W-1:0]  rej_count;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        last_good:      12'd400,
        rejected_value: '0,
        rej_count:      '0
    };

    // Everything the decision logic sees for one reading
    typedef struct packed {
        logic              failed;
        logic [RAW_W-1:0]  raw;
        logic              own_seeded;
        entry_t            own;
        logic              partner_ok;
        logic [TEMP_W-1:0] partner_good;
    } item_t;

    typedef struct packed {
        event_t            ev;
        logic [TEMP_W-1:0] temp;
        logic              wr_en;
        logic              set_seeded;
        entry_t            wr_entry;
    } decision_t;

endpackage

/* sv/tspf_decide.sv */
`timescale 1ns / 1ps
module tspf_decide (
    input  tspf_pkg::cfg_t      cfg,
    input  tspf_pkg::item_t     item,
    output tspf_pkg::decision_t dec
);
    import tspf_pkg::*;

    function automatic logic [TEMP_W-1:0] abs_diff(input logic [TEMP_W-1:0] a,
                                                   input logic [TEMP_W-1:0] b);
        logic signed [TEMP_W:0] d;
        logic [TEMP_W:0]        n;
        d = $signed({a[TEMP_W-1], a}) - $signed({b[TEMP_W-1], b});
        n = -d;
        return d[TEMP_W] ? n[TEMP_W-1:0] : d[TEMP_W-1:0];
    endfunction

    logic signed [RAW_W-1:0] low_ext;
    logic signed [RAW_W-1:0] high_ext;
    logic                    raw_plausible;
    logic [TEMP_W-1:0]       raw12;
    logic [TEMP_W-1:0]       hold_val;
    logic [TEMP_W-1:0]       step;
    logic [TEMP_W-1:0]       rep_dist;
    logic [TEMP_W-1:0]       partner_dist;
    logic [CNT_W-1:0]        cnt_upd;

    always_comb
    begin
        low_ext  = $signed({{(RAW_W-TEMP_W){cfg.low_limit[TEMP_W-1]}}, cfg.low_limit});
        high_ext = $signed({{(RAW_W-TEMP_W){cfg.high_limit[TEMP_W-1]}}, cfg.high_limit});
        raw_plausible = ($signed(item.raw) >= low_ext) && ($signed(item.raw) <= high_ext);
        raw12    = item.raw[TEMP_W-1:0];
        hold_val = item.own_seeded ? item.own.last_good : '0;

        step         = abs_diff(raw12, item.own.last_good);
        rep_dist     = abs_diff(raw12, item.own.rejected_value);
        partner_dist = abs_diff(raw12, item.partner_good);

        if (rep_dist < {1'b0, cfg.repeat_tolerance})
        begin
            cnt_upd = (item.own.rej_count == CNT_MAX) ? CNT_MAX
                                                      : item.own.rej_count + 4'd1;
        end
        else
        begin
            cnt_upd = 4'd1;
        end

        dec.ev         = EV_ACCEPTED;
        dec.temp       = raw12;
        dec.wr_en      = 1'b0;
        dec.set_seeded = 1'b0;
        dec.wr_entry   = item.own;

        if (item.failed)
        begin
            // partner value must be strictly above the low limit to stand in
            if (item.partner_ok &&
                ($signed(item.partner_good) > $signed(cfg.low_limit)))
            begin
                dec.ev   = EV_PARTNER_SUB;
                dec.temp = item.partner_good;
            end
            else
            begin
                dec.ev   = EV_FAIL_HOLD;
                dec.temp = hold_val;
            end
        end
        else if (!raw_plausible)
        begin
            dec.ev                  = EV_RANGE_HOLD;
            dec.temp                = hold_val;
            dec.wr_en               = 1'b1;
            dec.wr_entry.rej_count  = '0;
        end
        else if (!item.own_seeded)
        begin
            dec.ev                  = EV_SEEDED;
            dec.wr_en               = 1'b1;
            dec.set_seeded          = 1'b1;
            dec.wr_entry.last_good  = raw12;
            dec.wr_entry.rej_count  = '0;
        end
        else if (step > {1'b0, cfg.jump_limit})
        begin
            dec.wr_en                   = 1'b1;
            dec.wr_entry.rejected_value = raw12;
            if (cnt_upd >= cfg.recover_count)
            begin
                dec.wr_entry.rej_count = '0;
                if (item.partner_ok && (partner_dist < {1'b0, cfg.partner_tolerance}))
                begin
                    dec.ev                 = EV_RECOVERED;
                    dec.wr_entry.last_good = raw12;
                end
                else
                begin
                    dec.ev   = EV_PARTNER_DISAGREE;
                    dec.temp = item.own.last_good;
                end
            end
            else
            begin
                dec.ev                 = EV_JUMP_HOLD;
                dec.temp               = item.own.last_good;
                dec.wr_entry.rej_count = cnt_upd;
            end
        end
        else
        begin
            dec.wr_en              = 1'b1;
            dec.wr_entry.last_good = raw12;
            dec.wr_entry.rej_count = '0;
        end
    end

endmodule

/* sv/temp_sensor_plausibility_filter_core.sv */
`timescale 1ns / 1ps
// A reading is registered in the table read stage, then its decision in the output
// register once free. Throughput: one reading per cycle while the output is not
// stalled; the table read at acceptance and a write-back on that edge are bypassed,
// so back-to-back readings of one sensor see each other; a stalled output stalls the
// input once the read stage is full. Reset: asynchronous, clears the pipeline valids,
// seeded flags and loads the default limits; the per-sensor table needs no clearing.
module temp_sensor_plausibility_filter_core #(
    parameter int SENSOR_COUNT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] raw_temp
    input  logic [3:0]                       s_tuser,   // [2:0] sensor_index, [3] read_failed
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [11:0] filtered_temp, [15:12] zero
    output logic [2:0]                       m_tuser,   // [2:0] event_res
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tspf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tspf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tspf_pkg::*;

`include "temp_sensor_plausibility_filter_core_macros.svh"

    localparam int          SLOT_W  = $clog2(SENSOR_COUNT);
    localparam logic [6:0]  COUNT_V = 7'(SENSOR_COUNT);

    cfg_t cfg_reg;

    // per-sensor table, seeded flags double as entry valid bits
    entry_t                  mem [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] seeded_reg;

    logic                    s1_valid_reg;
    logic                    s1_keep_reg;
    logic [SLOT_W-1:0]       s1_slot_reg;
    logic                    s1_failed_reg;
    logic [RAW_W-1:0]        s1_raw_reg;
    logic                    own_seeded_reg;
    entry_t                  own_entry_reg;
    logic                    partner_ok_reg;
    logic [TEMP_W-1:0]       partner_good_reg;

    logic                    out_valid_reg;
    logic [TEMP_W-1:0]       out_temp_reg;
    event_t                  out_ev_reg;

    logic                    s_accept;
    logic                    s1_go;
    logic                    wr_fire;
    logic [SIDX_W-1:0]       in_idx;
    logic [4:0]              pbase;
    logic [SIDX_W-1:0]       in_pidx;
    logic                    idx_ok;
    logic                    pidx_ok;
    logic [SLOT_W-1:0]       in_slot;
    logic [SLOT_W-1:0]       in_pslot;
    logic                    own_hit;
    logic                    partner_hit;
    logic                    own_seeded_next;
    logic                    partner_seeded_next;
    item_t                   item;
    decision_t               dec;

    assign cfg_ready = 1'b1;

    assign in_idx   = s_tuser[SIDX_W-1:0];
    assign pbase    = {2'b00, in_idx} + {1'b0, in_idx, 1'b0};
    assign in_pidx  = cfg_reg.partner_map[pbase +: SIDX_W];
    assign idx_ok   = {4'b0000, in_idx} < COUNT_V;
    assign pidx_ok  = {4'b0000, in_pidx} < COUNT_V;
    assign in_slot  = SLOT_W'(in_idx);
    assign in_pslot = SLOT_W'(in_pidx);

    assign s1_go    = s1_valid_reg && (!s1_keep_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_accept = s_tvalid && s_tready;
    assign wr_fire  = s1_go && s1_keep_reg && dec.wr_en;

    // the item in the decision stage writes back on the same edge this read is taken
    assign own_hit     = wr_fire && (s1_slot_reg == in_slot);
    assign partner_hit = wr_fire && (s1_slot_reg == in_pslot);

    assign own_seeded_next     = idx_ok && (seeded_reg[in_slot] ||
                                 (own_hit && dec.set_seeded));
    assign partner_seeded_next = pidx_ok && (seeded_reg[in_pslot] ||
                                 (partner_hit && dec.set_seeded));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_JUMP_LIMIT:        cfg_reg.jump_limit        <= cfg_data[TOL_W-1:0];
                REG_LOW_LIMIT:         cfg_reg.low_limit         <= cfg_data[TEMP_W-1:0];
                REG_HIGH_LIMIT:        cfg_reg.high_limit        <= cfg_data[TEMP_W-1:0];
                REG_REPEAT_TOLERANCE:  cfg_reg.repeat_tolerance  <= cfg_data[TOL_W-1:0];
                REG_PARTNER_TOLERANCE: cfg_reg.partner_tolerance <= cfg_data[TOL_W-1:0];
                REG_RECOVER_COUNT:     cfg_reg.recover_count     <= cfg_data[CNT_W-1:0];
                REG_PARTNER_MAP:       cfg_reg.partner_map       <= cfg_data[MAP_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem[s1_slot_reg] <= dec.wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= '0;
        end
        else if (wr_fire && dec.set_seeded)
        begin
            seeded_reg[s1_slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // table read stage
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_keep_reg    <= idx_ok;
            s1_slot_reg    <= in_slot;
            s1_failed_reg  <= s_tuser[SIDX_W];
            s1_raw_reg     <= s_tdata[RAW_W-1:0];
            own_seeded_reg <= own_seeded_next;
            partner_ok_reg <= partner_seeded_next;
            if (!own_seeded_next)
            begin
                own_entry_reg <= ENTRY_RESET;
            end
            else if (own_hit)
            begin
                own_entry_reg <= dec.wr_entry;
            end
            else
            begin
                own_entry_reg <= mem[in_slot];
            end
            if (partner_hit)
            begin
                partner_good_reg <= dec.wr_entry.last_good;
            end
            else
            begin
                partner_good_reg <= mem[in_pslot].last_good;
            end
        end
    end

    always_comb
    begin
        item.failed       = s1_failed_reg;
        item.raw          = s1_raw_reg;
        item.own_seeded   = own_seeded_reg;
        item.own          = own_entry_reg;
        item.partner_ok   = partner_ok_reg;
        item.partner_good = partner_good_reg;
    end

    tspf_decide u_decide (
        .cfg  (cfg_reg),
        .item (item),
        .dec  (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_keep_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_keep_reg)
        begin
            out_temp_reg <= dec.temp;
            out_ev_reg   <= dec.ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-TEMP_W){1'b0}}, out_temp_reg};
    assign m_tuser  = out_ev_reg;

    `TSPF_ASSERT_NEXT(a_kept_item_reaches_output, s1_go && s1_keep_reg, out_valid_reg,
        "kept transaction did not reach output register")
    `TSPF_ASSERT_NOW(a_ready_when_output_free, !out_valid_reg, s_tready,
        "input stalled with empty output register")
    `TSPF_ASSERT_NEXT(a_seed_sticks, wr_fire && dec.set_seeded,
        seeded_reg[$past(s1_slot_reg)], "seeded flag not set after seeding")
    `TSPF_ASSERT_NOW(a_count_below_recover, wr_fire && (cfg_reg.recover_count != '0),
        dec.wr_entry.rej_count < cfg_reg.recover_count,
        "stored reject count reached recover count")

endmodule
